@@ hdl/clsf_pkg.sv @@
// Shared types and constants for the packet rule classifier.
// Used by every module of the block; depends on nothing else.

package clsf_pkg;

  localparam int RULE_SLOTS_DEF    = 32;
  localparam int COUNTER_SLOTS_DEF = 8;
  // Only the first SCAN_LIMIT rule slots take part in a lookup.
  localparam int SCAN_LIMIT        = 32;
  localparam int CNT_IDX_W         = 3;

  // Event counter numbers.
  localparam int CNT_FRAMES = 0;
  localparam int CNT_TCP    = 1;
  localparam int CNT_UDP    = 2;
  localparam int CNT_DROP   = 3;
  localparam int CNT_PASS   = 4;
  localparam int CNT_USER   = 5;

  typedef enum logic [1:0] {
    ACT_PKT  = 2'd0,
    ACT_RULE = 2'd1,
    ACT_CNT  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    VERD_DROP = 2'd0,
    VERD_PASS = 2'd1,
    VERD_USER = 2'd2,
    VERD_SKIP = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_L4,
    ST_SCAN,
    ST_FINAL,
    ST_CNT_RD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] address;
    logic [15:0] port;
    logic [7:0]  protocol;
    logic        present;
  } rule_t;

  typedef struct packed {
    logic       en;
    logic [4:0] idx;
    rule_t      entry;
  } rule_wr_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [15:0] port;
    logic [31:0] address;
  } scan_key_t;

  typedef struct packed {
    logic     done;
    verdict_t verdict;
  } scan_res_t;

  typedef struct packed {
    logic [6:0]  pos;
    logic [15:0] ethertype;
    logic [7:0]  ver_len;
    logic [7:0]  protocol;
    logic [31:0] daddr;
    logic [15:0] dport;
  } hdr_t;

  typedef struct packed {
    logic                 bump;
    logic                 read;
    logic [CNT_IDX_W-1:0] idx;
  } cnt_req_t;

  typedef struct packed {
    logic     early;
    verdict_t early_verdict;
    logic     l4_bump;
    logic     l4_udp;
  } cls_t;

endpackage

@@ hdl/clsf_parse.sv @@
// Header field capture for the packet rule classifier.
// Tracks the byte position in the frame; depends on clsf_pkg.

module clsf_parse
  import clsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] byte_in,
  input  logic       clear,
  output hdr_t       hdr
);

  logic [6:0]  pos_r, pos_nxt;
  logic [15:0] eth_r, eth_nxt;
  logic [7:0]  vl_r, vl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] daddr_r, daddr_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [6:0]  l4;

  // Start of the L4 header, in frame bytes.
  assign l4 = 7'd14 + {1'b0, vl_r[3:0], 2'b00};

  always_comb begin
    pos_nxt   = pos_r;
    eth_nxt   = eth_r;
    vl_nxt    = vl_r;
    proto_nxt = proto_r;
    daddr_nxt = daddr_r;
    dport_nxt = dport_r;
    if (clear) begin
      pos_nxt   = '0;
      eth_nxt   = '0;
      vl_nxt    = '0;
      proto_nxt = '0;
      daddr_nxt = '0;
      dport_nxt = '0;
    end else if (byte_en) begin
      case (pos_r)
        7'd12:   eth_nxt[15:8]    = byte_in;
        7'd13:   eth_nxt[7:0]     = byte_in;
        7'd14:   vl_nxt           = byte_in;
        7'd23:   proto_nxt        = byte_in;
        7'd30:   daddr_nxt[31:24] = byte_in;
        7'd31:   daddr_nxt[23:16] = byte_in;
        7'd32:   daddr_nxt[15:8]  = byte_in;
        7'd33:   daddr_nxt[7:0]   = byte_in;
        default: ;
      endcase
      if (pos_r > 7'd14) begin
        if (pos_r == l4 + 7'd2) begin
          dport_nxt[15:8] = byte_in;
        end else if (pos_r == l4 + 7'd3) begin
          dport_nxt[7:0] = byte_in;
        end
      end
      // The position saturates so that long frames never wrap.
      if (pos_r != 7'd127) begin
        pos_nxt = pos_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      eth_r   <= '0;
      vl_r    <= '0;
      proto_r <= '0;
      daddr_r <= '0;
      dport_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      eth_r   <= eth_nxt;
      vl_r    <= vl_nxt;
      proto_r <= proto_nxt;
      daddr_r <= daddr_nxt;
      dport_r <= dport_nxt;
    end
  end

  assign hdr = '{pos: pos_r, ethertype: eth_r, ver_len: vl_r, protocol: proto_r,
                 daddr: daddr_r, dport: dport_r};

endmodule

@@ hdl/clsf_rules.sv @@
// Rule table memory and first-match scan for the packet rule classifier.
// One entry is read and compared per cycle; depends on clsf_pkg.

module clsf_rules
  import clsf_pkg::*;
#(
  parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  rule_wr_t  wr,
  input  logic      start,
  input  scan_key_t key,
  output scan_res_t res
);

  localparam int DEPTH = (RULE_SLOTS < SCAN_LIMIT) ? RULE_SLOTS : SCAN_LIMIT;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [5:0] DEPTH6 = 6'(DEPTH);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DEPTH);

  rule_t             mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  rule_t             rd_data_r;
  logic              rd_vld_r;
  logic              busy_r, busy_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              issue;
  logic              hit;
  logic              wr_ok;

  assign wr_ok = wr.en && ({1'b0, wr.idx} < DEPTH6);

  // Entries never written since reset read as not present.
  assign hit = pend_r && rd_vld_r && rd_data_r.present &&
               (rd_data_r.verdict != VERD_SKIP) &&
               (rd_data_r.protocol == 8'd0 || rd_data_r.protocol == key.protocol) &&
               (rd_data_r.port == 16'd0 || rd_data_r.port == key.port) &&
               (rd_data_r.address == 32'd0 || rd_data_r.address == key.address);

  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    issue    = 1'b0;
    res      = '{done: 1'b0, verdict: VERD_USER};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (hit) begin
        res      = '{done: 1'b1, verdict: rd_data_r.verdict};
        busy_nxt = 1'b0;
      end else if (cnt_r == LAST_CNT) begin
        res      = '{done: 1'b1, verdict: VERD_USER};
        busy_nxt = 1'b0;
      end else begin
        issue    = 1'b1;
        pend_nxt = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
      valid_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      if (wr_ok) begin
        valid_r[wr.idx[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.idx[IDX_W-1:0]] <= wr.entry;
    end
    if (issue) begin
      rd_data_r <= mem[cnt_r[IDX_W-1:0]];
      rd_vld_r  <= valid_r[cnt_r[IDX_W-1:0]];
    end
  end

endmodule

@@ hdl/clsf_counters.sv @@
// Event counter memory for the packet rule classifier.
// Increments by a read, then an add and write-back in the cycle after; depends on clsf_pkg.

module clsf_counters
  import clsf_pkg::*;
#(
  parameter int COUNTER_SLOTS = COUNTER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cnt_req_t    req,
  output logic [63:0] rd_value
);

  localparam int AW = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1;

  logic [63:0]              mem [COUNTER_SLOTS];
  logic [COUNTER_SLOTS-1:0] valid_r;
  logic [63:0]              q_r;
  logic                     q_vld_r;
  logic                     inc_r;
  logic [AW-1:0]            inc_idx_r;
  logic [AW-1:0]            addr;

  assign addr     = req.idx[AW-1:0];
  // A counter never written since reset reads as zero.
  assign rd_value = q_vld_r ? q_r : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      inc_r   <= 1'b0;
      q_vld_r <= 1'b0;
    end else begin
      inc_r <= req.bump;
      if (req.bump || req.read) begin
        q_vld_r <= valid_r[addr];
      end
      if (inc_r) begin
        valid_r[inc_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    inc_idx_r <= addr;
    if (req.bump || req.read) begin
      q_r <= mem[addr];
    end
    if (inc_r) begin
      mem[inc_idx_r] <= rd_value + 64'd1;
    end
  end

endmodule

@@ hdl/packet_rule_classifier.sv @@
// Top level of the packet rule classifier: channel ports, sequencer and output register.
// Instantiates clsf_parse, clsf_rules and clsf_counters; depends on clsf_pkg.
//
//  Channel   Direction  Handshake            Contents
//  in_*      input      in_tvalid/tready     frame byte, rule write or counter read
//  out_*     output     out_tvalid/tready    frame verdict or counter value
//
// Frame bytes that are not the last, and rule writes, are taken one per cycle while the
// sequencer is idle. After the last byte of a frame the sequencer runs the header
// checks, bumps a TCP or UDP counter for such frames, scans the rule slots one per cycle
// up to the table depth (ending early at the first matching rule, and skipped when the
// header checks already give the verdict), bumps the final counter and loads the output
// register. A counter read passes through a read state before the output register is
// loaded. The scan reads one rule per cycle from the rule memory; the counter memory
// reads one entry and writes back another in the same cycle. Reset is synchronous and
// active low; the rule table and the counters are valid-bit tracked, so no clearing
// pass follows reset. A stalled output only holds the block when a new result is ready
// and the output register is still full.

module packet_rule_classifier
  import clsf_pkg::*;
#(
  parameter int RULE_SLOTS    = RULE_SLOTS_DEF,
  parameter int COUNTER_SLOTS = COUNTER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] packet_byte, [12:8] entry_index, [13] rule_present, [21:14] rule_protocol,
  // [37:22] rule_port, [69:38] rule_address, [71:70] rule_verdict
  input  logic [71:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] verdict, [65:2] counter_value, [71:66] zero
  output logic [71:0] out_tdata,
  // [0] result_kind
  output logic        out_tuser
);

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Input transaction fields.
  logic [7:0]  in_byte;
  logic [4:0]  in_idx;
  rule_t       in_rule;
  action_t     in_action;
  logic        in_fire;

  assign in_byte   = in_tdata[7:0];
  assign in_idx    = in_tdata[12:8];
  assign in_rule   = '{verdict: verdict_t'(in_tdata[71:70]), address: in_tdata[69:38],
                       port: in_tdata[37:22], protocol: in_tdata[21:14],
                       present: in_tdata[13]};
  assign in_action = action_t'(in_tuser);
  assign in_fire   = in_tvalid && in_tready;

  state_t      state_r, state_nxt;
  logic [7:0]  len_r;
  cls_t        cls, cls_r;
  verdict_t    verdict_r;
  logic        kind_r;
  logic [4:0]  cidx_r;
  logic        cnt_ok_r;
  logic        out_valid_r;
  logic        out_kind_r;
  verdict_t    out_verdict_r;
  logic [63:0] out_count_r;
  logic        out_free;
  logic        out_load;

  hdr_t        hdr;
  rule_wr_t    rule_wr;
  scan_key_t   key;
  scan_res_t   scan_res;
  logic        scan_start;
  cnt_req_t    cnt_req;
  logic [63:0] cnt_value;
  logic        parse_clear;

  clsf_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (in_fire && in_action == ACT_PKT),
    .byte_in (in_byte),
    .clear   (parse_clear),
    .hdr     (hdr)
  );

  assign rule_wr = '{en: in_fire && in_action == ACT_RULE, idx: in_idx, entry: in_rule};

  clsf_rules #(.RULE_SLOTS(RULE_SLOTS)) u_rules (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (rule_wr),
    .start (scan_start),
    .key   (key),
    .res   (scan_res)
  );

  clsf_counters #(.COUNTER_SLOTS(COUNTER_SLOTS)) u_counters (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (cnt_req),
    .rd_value (cnt_value)
  );

  // Header checks on the captured fields once the frame has ended.
  logic [3:0] ihl;
  logic [7:0] l4_start;
  logic       is_tcp, is_udp;

  assign ihl      = hdr.ver_len[3:0];
  assign l4_start = 8'd14 + {2'b00, ihl, 2'b00};
  assign is_tcp   = hdr.protocol == PROTO_TCP;
  assign is_udp   = hdr.protocol == PROTO_UDP;

  always_comb begin
    cls = '{early: 1'b0, early_verdict: VERD_USER, l4_bump: 1'b0, l4_udp: is_udp};
    if (len_r < 8'd14 || hdr.ethertype != ETH_IPV4) begin
      cls.early         = 1'b1;
      cls.early_verdict = VERD_PASS;
    end else if (len_r < 8'd34 || hdr.ver_len[7:4] != 4'd4 || ihl < 4'd5) begin
      cls.early         = 1'b1;
      cls.early_verdict = VERD_DROP;
    end else if (is_tcp) begin
      cls.l4_bump = 1'b1;
      if (len_r < l4_start + 8'd20) begin
        cls.early         = 1'b1;
        cls.early_verdict = VERD_DROP;
      end
    end else if (is_udp) begin
      cls.l4_bump = 1'b1;
      if (len_r < l4_start + 8'd8) begin
        cls.early         = 1'b1;
        cls.early_verdict = VERD_DROP;
      end
    end
  end

  // Protocols other than TCP and UDP match rules with a port of zero.
  assign key = '{protocol: hdr.protocol, port: (is_tcp || is_udp) ? hdr.dport : 16'd0,
                 address: hdr.daddr};

  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_PKT && in_tlast) begin
            state_nxt = ST_DECIDE;
          end else if (in_action == ACT_CNT) begin
            state_nxt = ST_CNT_RD;
          end
        end
      end
      ST_DECIDE: begin
        if (cls.l4_bump) begin
          state_nxt = ST_L4;
        end else if (cls.early) begin
          state_nxt = ST_FINAL;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_L4: begin
        state_nxt = cls_r.early ? ST_FINAL : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL:  state_nxt = ST_EMIT;
      ST_CNT_RD: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready   = 1'b0;
    scan_start  = (state_nxt == ST_SCAN) && (state_r != ST_SCAN);
    parse_clear = 1'b0;
    out_load    = 1'b0;
    cnt_req     = '{bump: 1'b0, read: 1'b0, idx: '0};
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_DECIDE: cnt_req = '{bump: 1'b1, read: 1'b0, idx: CNT_IDX_W'(CNT_FRAMES)};
      ST_L4: begin
        cnt_req = '{bump: 1'b1, read: 1'b0,
                    idx: cls_r.l4_udp ? CNT_IDX_W'(CNT_UDP) : CNT_IDX_W'(CNT_TCP)};
      end
      ST_FINAL: begin
        parse_clear = 1'b1;
        cnt_req.bump = 1'b1;
        case (verdict_r)
          VERD_DROP: cnt_req.idx = CNT_IDX_W'(CNT_DROP);
          VERD_PASS: cnt_req.idx = CNT_IDX_W'(CNT_PASS);
          default:   cnt_req.idx = CNT_IDX_W'(CNT_USER);
        endcase
      end
      ST_CNT_RD: cnt_req = '{bump: 1'b0, read: cnt_ok_r, idx: cidx_r[CNT_IDX_W-1:0]};
      ST_EMIT:   out_load = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      len_r    <= {1'b0, hdr.pos} + 8'd1;
      kind_r   <= (in_action == ACT_CNT);
      cidx_r   <= in_idx;
      cnt_ok_r <= in_idx < 5'(COUNTER_SLOTS);
    end
    if (state_r == ST_DECIDE) begin
      cls_r     <= cls;
      verdict_r <= cls.early_verdict;
    end
    if (state_r == ST_SCAN && scan_res.done) begin
      verdict_r <= scan_res.verdict;
    end
    if (out_load) begin
      out_kind_r    <= kind_r;
      out_verdict_r <= kind_r ? VERD_DROP : verdict_r;
      out_count_r   <= (kind_r && cnt_ok_r) ? cnt_value : 64'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_count_r, out_verdict_r};

`ifndef ASSERT_OFF
  // The rule scan only reports a result while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> state_r == ST_SCAN)
    else $error("rule scan finished outside the scan state");

  // The last byte of a frame always starts the header checks.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_PKT && in_tlast |=> state_r == ST_DECIDE)
    else $error("frame end did not start a verdict");

  // A new result only enters the output register from the emit state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_EMIT)
    else $error("output loaded outside the emit state");

  // A counter is never read while an increment is issued.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_req.read |-> !cnt_req.bump && !$past(cnt_req.bump))
    else $error("counter read overlaps an increment");
`endif

endmodule
